/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the frame reader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SARF_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Implication with the consequent checked in the same cycle.
`define SARF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define SARF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sarf_pkg.sv */
// ----------------------------------------------------------------------------
// SARF package
// Constants, types and helper functions of the serial ADC frame reader.
// ----------------------------------------------------------------------------
package sarf_pkg;

   localparam int unsigned SAMPLE_BITS = 13;
   localparam int unsigned SAMPLE_W    = 13;
   localparam int unsigned LEAD_BITS   = 3;
   localparam int unsigned TICK_W      = 10;
   localparam int unsigned INDEX_W     = $clog2(LEAD_BITS + SAMPLE_BITS + 1);
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned EXT_W       = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_CS_IDLE     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_CS_SETUP    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_PERIOD = CSR_ADDR_W'(2);

   localparam logic [TICK_W-1:0] CS_IDLE_RESET     = TICK_W'(58);
   localparam logic [TICK_W-1:0] CS_SETUP_RESET    = TICK_W'(10);
   localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = TICK_W'(30);

   localparam logic [INDEX_W-1:0] NULL_INDEX  = INDEX_W'(LEAD_BITS - 1);
   localparam logic [INDEX_W-1:0] FIRST_DATA  = INDEX_W'(LEAD_BITS);
   localparam logic [INDEX_W-1:0] LAST_INDEX  = INDEX_W'(LEAD_BITS + SAMPLE_BITS);

   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((2 ** (SAMPLE_W - 1)) - 1);
   localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

   typedef struct packed {
      logic [TICK_W-1:0] cs_idle_ticks;
      logic [TICK_W-1:0] cs_setup_ticks;
      logic [TICK_W-1:0] half_period_ticks;
   } sarf_cfg_type;

   // Sign-extends the raw shifted bits and clamps them to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] sample_field(
      input logic [SAMPLE_BITS-1:0] raw
   );
      logic signed [EXT_W-1:0] ext;
      ext = EXT_W'(signed'(raw));
      if (ext > SAT_HI) begin
         ext = SAT_HI;
      end else if (ext < SAT_LO) begin
         ext = SAT_LO;
      end
      return SAMPLE_W'(ext);
   endfunction

endpackage

/* sv/sarf_channels.sv */
// ----------------------------------------------------------------------------
// SARF channels
// Valid/ready interfaces for the tick, result and register write channels.
// ----------------------------------------------------------------------------
interface sarf_req_if import sarf_pkg::*; ();
   logic valid;
   logic ready;
   logic start_req;
   logic data_pin;

   modport source (output valid, output start_req, output data_pin, input ready);
   modport sink   (input valid, input start_req, input data_pin, output ready);
endinterface

interface sarf_rsp_if import sarf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       chip_select_n;
   logic                       serial_clock;
   logic                       busy_res;
   logic                       done_res;
   logic                       error;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output chip_select_n, output serial_clock,
                   output busy_res, output done_res, output error, output sample,
                   input ready);
   modport sink   (input valid, input chip_select_n, input serial_clock,
                   input busy_res, input done_res, input error, input sample,
                   output ready);
endinterface

interface sarf_csr_if import sarf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [TICK_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sarf_csr.sv */
// ----------------------------------------------------------------------------
// SARF register file
// Holds the three timing registers and takes writes from the register channel.
// ----------------------------------------------------------------------------
module sarf_csr import sarf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   sarf_csr_if.sink       csr_chan,
   output sarf_cfg_type   cfg
);

   sarf_cfg_type cfg_ff;
   sarf_cfg_type cfg_in;
   logic         write_en;

   assign csr_chan.ready = 1'b1;
   assign write_en       = csr_chan.valid && csr_chan.ready;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_chan.index)
            CSR_CS_IDLE:     cfg_in.cs_idle_ticks     = csr_chan.data;
            CSR_CS_SETUP:    cfg_in.cs_setup_ticks    = csr_chan.data;
            CSR_HALF_PERIOD: cfg_in.half_period_ticks = csr_chan.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cs_idle_ticks     <= CS_IDLE_RESET;
         cfg_ff.cs_setup_ticks    <= CS_SETUP_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/spi_adc_frame_reader.sv */
// ----------------------------------------------------------------------------
// SPI ADC frame reader
// Tick-stepped read controller for a serial ADC with a null bit check.
//
//   Channel    Dir   Payload
//   req_chan   in    start_req, data_pin (one clock tick each item)
//   rsp_chan   out   chip_select_n, serial_clock, busy_res, done_res, error,
//                    sample
//   csr_chan   in    index, data (timing register writes)
//
// Each item produces exactly one result item: the item is held in the input
// register, then stepping the frame state loads the result register. One item
// is accepted per cycle while the result channel is not stalled. A stalled
// result holds the step; the input register then fills and ready drops.
// Reset returns the frame to idle and the registers to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_adc_frame_reader import sarf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sarf_req_if.sink    req_chan,
   sarf_rsp_if.source  rsp_chan,
   sarf_csr_if.sink    csr_chan
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CS_HIGH,
      PH_SETUP,
      PH_CLK_HIGH,
      PH_CLK_LOW
   } phase_type;

   sarf_cfg_type cfg;

   logic in_valid_ff;
   logic in_start_ff;
   logic in_pin_ff;
   logic advance;

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    wait_ff, wait_in;
   logic [INDEX_W-1:0]   bit_ff, bit_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic                 clk_ff, clk_in;
   logic                 sel_ff, sel_in;
   logic                 done_in;
   logic                 err_in;
   logic signed [SAMPLE_W-1:0] smp_in;

   logic                 rsp_valid_ff;
   logic                 rsp_sel_ff;
   logic                 rsp_clk_ff;
   logic                 rsp_busy_ff;
   logic                 rsp_done_ff;
   logic                 rsp_err_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   sarf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.chip_select_n = rsp_sel_ff;
   assign rsp_chan.serial_clock  = rsp_clk_ff;
   assign rsp_chan.busy_res      = rsp_busy_ff;
   assign rsp_chan.done_res      = rsp_done_ff;
   assign rsp_chan.error         = rsp_err_ff;
   assign rsp_chan.sample        = rsp_sample_ff;

   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      clk_in   = clk_ff;
      sel_in   = sel_ff;
      done_in  = 1'b0;
      err_in   = 1'b0;
      smp_in   = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (in_start_ff) begin
               phase_in = PH_CS_HIGH;
               wait_in  = TICK_W'(1);
               sel_in   = 1'b1;
               clk_in   = 1'b0;
               bit_in   = '0;
               shift_in = '0;
            end
         end
         PH_CS_HIGH: begin
            if (wait_ff >= cfg.cs_idle_ticks) begin
               phase_in = PH_SETUP;
               wait_in  = TICK_W'(1);
               sel_in   = 1'b0;
            end else begin
               wait_in = wait_ff + TICK_W'(1);
            end
         end
         PH_SETUP: begin
            if (wait_ff >= cfg.cs_setup_ticks) begin
               phase_in = PH_CLK_HIGH;
               wait_in  = TICK_W'(1);
               clk_in   = 1'b1;
            end else begin
               wait_in = wait_ff + TICK_W'(1);
            end
         end
         PH_CLK_HIGH: begin
            if (wait_ff >= cfg.half_period_ticks) begin
               clk_in = 1'b0;
               if (bit_ff == NULL_INDEX && in_pin_ff) begin
                  phase_in = PH_IDLE;
                  wait_in  = '0;
                  bit_in   = '0;
                  sel_in   = 1'b1;
                  done_in  = 1'b1;
                  err_in   = 1'b1;
               end else begin
                  if (bit_ff >= FIRST_DATA) begin
                     shift_in = {shift_ff[SAMPLE_BITS-2:0], in_pin_ff};
                  end
                  bit_in   = bit_ff + INDEX_W'(1);
                  phase_in = PH_CLK_LOW;
                  wait_in  = TICK_W'(1);
               end
            end else begin
               wait_in = wait_ff + TICK_W'(1);
            end
         end
         PH_CLK_LOW: begin
            if (wait_ff >= cfg.half_period_ticks) begin
               if (bit_ff >= LAST_INDEX) begin
                  phase_in = PH_IDLE;
                  wait_in  = '0;
                  bit_in   = '0;
                  clk_in   = 1'b0;
                  sel_in   = 1'b1;
                  done_in  = 1'b1;
                  smp_in   = sample_field(shift_ff);
               end else begin
                  phase_in = PH_CLK_HIGH;
                  wait_in  = TICK_W'(1);
                  clk_in   = 1'b1;
               end
            end else begin
               wait_in = wait_ff + TICK_W'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
            wait_in  = '0;
            bit_in   = '0;
            clk_in   = 1'b0;
            sel_in   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         clk_ff       <= 1'b0;
         sel_ff       <= 1'b1;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
            in_start_ff <= req_chan.start_req;
            in_pin_ff   <= req_chan.data_pin;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff      <= phase_in;
            wait_ff       <= wait_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            clk_ff        <= clk_in;
            sel_ff        <= sel_in;
            rsp_valid_ff  <= 1'b1;
            rsp_sel_ff    <= sel_in;
            rsp_clk_ff    <= clk_in;
            rsp_busy_ff   <= (phase_in != PH_IDLE);
            rsp_done_ff   <= done_in;
            rsp_err_ff    <= err_in;
            rsp_sample_ff <= smp_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `SARF_ASSERT_IMPLY(a_err_has_done, rsp_valid_ff && rsp_err_ff, rsp_done_ff,
      "error reported without frame completion")
   `SARF_ASSERT_IMPLY(a_err_zero_sample, rsp_valid_ff && rsp_err_ff, rsp_sample_ff == '0,
      "nonzero sample reported with error")
   `SARF_ASSERT_IMPLY(a_idle_lines, phase_ff == PH_IDLE, sel_ff && !clk_ff,
      "idle frame state drives select low or clock high")
   `SARF_ASSERT_IMPLY(a_select_busy, rsp_valid_ff && !rsp_sel_ff, rsp_busy_ff,
      "chip select low while not busy")
   `SARF_ASSERT_NEXT(a_done_goes_idle, advance && done_in, phase_ff == PH_IDLE,
      "frame end did not return to idle")

endmodule
